// File: rtl/gray_level_histogram_defines.svh
// assertion macros shared by the histogram checker
`ifndef GRAY_LEVEL_HISTOGRAM_DEFINES_SVH
`define GRAY_LEVEL_HISTOGRAM_DEFINES_SVH

// same-cycle implication, dropped while reset is asserted
`define GLH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked during reset as well
`define GLH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/glh_pkg.sv
// shared constants, item types and helpers of the gray-level histogram
package glh_pkg;

  localparam int BIN_COUNT   = 256;
  localparam int COUNT_BITS  = 24;
  localparam int BIN_W       = $clog2(BIN_COUNT);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [8:0]            BIN_LIMIT = 9'(BIN_COUNT);
  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;
  localparam logic [7:0]            MAX_GRAY_RST = 8'd255;

  typedef enum logic {
    ACT_COUNT = 1'b0,
    ACT_READ  = 1'b1
  } action_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] pixel_value;
    logic [7:0] bin_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  bin_number;
    logic [23:0] bin_count;
  } out_item_t;

  // classified work item passed from the front end to the back end
  typedef struct packed {
    action_t          op;
    logic [BIN_W-1:0] addr;
    logic [7:0]       bin_number;
    logic             in_range;
  } job_t;

  // counter value as seen on the result port
  function automatic logic [23:0] out_count(input logic [COUNT_BITS-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[23:0];
  endfunction

endpackage

// File: rtl/glh_ram.sv
// generic single-write, single-read ram with registered read data
module glh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, returns the value held before a same-cycle write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/glh_front.sv
// front end: takes items, holds max_gray and classifies items into jobs
module glh_front
  import glh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       queue_full,
  output logic       push,
  output job_t       job
);

  logic [7:0] max_gray_r;
  logic [7:0] max_gray_nxt;
  logic       pix_in_range;
  logic       idx_in_range;
  logic       keep;

  // configuration register
  always_comb begin
    max_gray_nxt = max_gray_r;
    if (cfg_we) begin
      max_gray_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_gray_r <= MAX_GRAY_RST;
    end else begin
      max_gray_r <= max_gray_nxt;
    end
  end

  // classify the item: out-of-range pixels are dropped here
  assign pix_in_range = ({1'b0, in_item.pixel_value} < BIN_LIMIT) &&
                        (in_item.pixel_value <= max_gray_r);
  assign idx_in_range = {1'b0, in_item.bin_index} < BIN_LIMIT;
  assign keep         = (in_item.action == ACT_READ) || pix_in_range;

  assign busy = queue_full;
  assign push = start && !busy && keep;

  always_comb begin
    job.op         = in_item.action;
    job.bin_number = in_item.bin_index;
    if (in_item.action == ACT_READ) begin
      job.addr     = in_item.bin_index[BIN_W-1:0];
      job.in_range = idx_in_range;
    end else begin
      job.addr     = in_item.pixel_value[BIN_W-1:0];
      job.in_range = 1'b1;
    end
  end

endmodule

// File: rtl/glh_queue.sv
// short job queue between front end and back end
module glh_queue
  import glh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = cnt_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_job   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/glh_back.sv
// back end: read-modify-write of the bin counters with write forwarding
module glh_back
  import glh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  job_t      head_job,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_item
);

  logic [BIN_COUNT-1:0]  written_r, written_nxt;
  logic                  s2_valid_r;
  job_t                  s2_job_r;
  logic                  s2_written_r;
  logic                  fwd_valid_r;
  logic [BIN_W-1:0]      fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_data_r;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] old_count;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  wr_en;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  // the back end never stalls, so every queued job is taken at once
  assign pop = head_valid;

  glh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BIN_COUNT)
  ) u_bins (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s2_job_r.addr),
    .wdata (wr_data),
    .re    (pop),
    .raddr (head_job.addr),
    .rdata (ram_rdata)
  );

  // read stage: job moves on while the ram fetches its bin
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_job_r     <= head_job;
      s2_written_r <= written_r[head_job.addr];
    end
  end

  // old count: last cycle's write wins, a never-written bin reads as zero
  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s2_job_r.addr)) begin
      old_count = fwd_data_r;
    end else if (s2_written_r) begin
      old_count = ram_rdata;
    end else begin
      old_count = '0;
    end
  end

  // update stage: saturating increment or clear after read
  assign wr_en = s2_valid_r && s2_job_r.in_range;

  always_comb begin
    if (s2_job_r.op == ACT_READ) begin
      wr_data = '0;
    end else if (old_count == COUNT_TOP) begin
      wr_data = old_count;
    end else begin
      wr_data = old_count + COUNT_BITS'(1);
    end
  end

  // per-bin written flags stand in for clearing the ram after reset
  always_comb begin
    written_nxt = written_r;
    if (wr_en) begin
      written_nxt[s2_job_r.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r   <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      written_r   <= written_nxt;
      fwd_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr_r <= s2_job_r.addr;
      fwd_data_r <= wr_data;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt           = s2_valid_r && (s2_job_r.op == ACT_READ);
    out_item_nxt.bin_number = s2_job_r.bin_number;
    if (s2_job_r.in_range) begin
      out_item_nxt.bin_count = out_count(old_count);
    end else begin
      out_item_nxt.bin_count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_nxt) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: rtl/gray_level_histogram.sv
// top level of the gray-level histogram engine
//
// Input items are taken on start while busy is low. A count item (action 0)
// bumps the saturating counter of pixel_value; pixels above max_gray are
// dropped. A read item (action 1) returns bin_index and that bin's count on
// out_item with out_valid high for one cycle, and clears the bin.
// Throughput: one item per clock while busy is low. The counter ram is read and written once
// per cycle, and a one-entry write-forward register covers back-to-back
// items that hit the same bin.
// A read item's result passes through the queue slot, the ram read and
// update stage and the result register before it reaches out_item.
// Count items produce no result.
// The receiver cannot stall; the back end never waits, so the four-entry
// queue stays nearly empty and busy only rises if it ever fills.
// max_gray is written through cfg_we/cfg_wdata, by the user only while no item is in flight (not enforced).
// Reset (rst_n low, synchronous) sets max_gray to 255 and marks every bin
// as never written, so all counts read as zero with no clearing pass.
module gray_level_histogram
  import glh_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic queue_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  glh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .queue_full (queue_full),
    .push       (push),
    .job        (push_job)
  );

  glh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  glh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_item   (out_item)
  );

endmodule

// File: rtl/glh_checker.sv
// port-level checker for the histogram engine and its bind
`include "gray_level_histogram_defines.svh"

module glh_checker
  import glh_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  logic take_read;
  logic take_count;

  assign take_read  = start && !busy && (in_item.action == ACT_READ);
  assign take_count = start && !busy && (in_item.action == ACT_COUNT);

  // reset empties the pipeline
  `GLH_ASSERT_NEXT(a_reset_quiet, !rst_n, !out_valid, "result right after reset")

  // every read item gives a result for the bin it named
  `GLH_ASSERT_NOW(a_read_result, take_read, ##3 out_valid, "read item without result")
  `GLH_ASSERT_NOW(a_read_bin, take_read, ##3 (out_item.bin_number == $past(in_item.bin_index, 3)), "result for wrong bin")

  // count items stay silent
  `GLH_ASSERT_NOW(a_count_silent, take_count, ##3 !out_valid, "result from a count item")

endmodule

bind gray_level_histogram glh_checker u_glh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
